FILE: rtl/iddl_pkg.sv
// shared types and codes for the indexed insert/delete list unit
package iddl_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // cmd stays a plain vector: codes 5 to 7 arrive and must be answered
  typedef struct packed {
    logic        [2:0]  cmd;
    logic        [7:0]  position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [7:0]  list_length;
    logic signed [31:0] read_data;
  } rsp_t;

  // per-cycle control broadcast to every cell, already qualified by status ok
  typedef struct packed {
    logic ins;
    logic del;
    logic upd;
    logic rd;
  } cell_ctl_t;

endpackage

FILE: rtl/iddl_cell.sv
// one list slot: holds an entry and trades it with its neighbors
module iddl_cell #(
  parameter int IDX = 0,
  parameter int PW  = 8
) (
  input  logic                    clk_i,
  input  iddl_pkg::cell_ctl_t     ctl_i,
  input  logic [PW-1:0]           pos_i,
  input  logic signed [31:0]      val_i,
  input  logic signed [31:0]      left_i,
  input  logic signed [31:0]      right_i,
  output logic signed [31:0]      entry_o,
  output logic signed [31:0]      rd_o
);

  localparam logic [PW-1:0] MyIdx = PW'(IDX);

  logic signed [31:0] entry_q, entry_d;
  logic               hit, above;

  assign hit   = (pos_i == MyIdx);
  assign above = (MyIdx > pos_i);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (hit) begin
        entry_d = val_i;
      end else if (above) begin
        entry_d = left_i;
      end
    end else if (ctl_i.del) begin
      if (hit || above) begin
        entry_d = right_i;
      end
    end else if (ctl_i.upd && hit) begin
      entry_d = val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // masked for the or-tree of the read path
  assign rd_o    = (ctl_i.rd && hit) ? entry_q : 32'sd0;

endmodule

FILE: rtl/indexed_insert_delete_list_unit.sv
// indexed insert/delete list unit: row of list cells with shared command decode
// clear, insert, update, delete and any rejected request answer in the cycle after accept
// a successful read answers through a two-stage or-tree: the group registers, then the response register
// throughput: one request per cycle, except a read which holds busy high for one cycle
// reset: length cleared to zero and no response pending; entry contents are not reset
// the receiver cannot stall: every response is shown for exactly one cycle on done_o
module indexed_insert_delete_list_unit #(
  parameter int DEPTH = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  iddl_pkg::req_t      req_i,
  output logic                done_o,
  output iddl_pkg::rsp_t      rsp_o
);

  // count width must hold DEPTH itself; compares run at the wider of that and the position
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int WW   = (CW > 8) ? CW : 8;
  localparam int GS   = 16;
  localparam int NGRP = (DEPTH + GS - 1) / GS;
  localparam logic [WW-1:0] DepthW = WW'(DEPTH);

  logic                      acc;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [WW-1:0]             cnt_w, cnt_dw, pos_w;
  logic [1:0]                status;
  logic                      ok;
  iddl_pkg::cell_ctl_t       ctl;

  logic [DEPTH-1:0][31:0]    ent_w;
  logic [DEPTH-1:0][31:0]    rd_w;
  logic [NGRP-1:0][31:0]     grp_d, grp_q;
  logic [31:0]               tree_or;

  logic                      done_q, rd_pend_q;
  iddl_pkg::rsp_t            rsp_q;

  assign acc   = start && !busy;
  assign busy  = rd_pend_q;
  assign cnt_w = WW'(cnt_q);
  assign pos_w = WW'(req_i.position);

  // status decode: full is checked ahead of position, empty ahead of range
  always_comb begin
    status = iddl_pkg::ST_OK;
    unique case (req_i.cmd) inside
      iddl_pkg::CMD_CLEAR: begin
        status = iddl_pkg::ST_OK;
      end
      iddl_pkg::CMD_INSERT: begin
        if (cnt_w >= DepthW) begin
          status = iddl_pkg::ST_FULL;
        end else if (pos_w > cnt_w) begin
          status = iddl_pkg::ST_RANGE;
        end
      end
      iddl_pkg::CMD_UPDATE, iddl_pkg::CMD_DELETE, iddl_pkg::CMD_READ: begin
        if (cnt_w == '0) begin
          status = iddl_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status = iddl_pkg::ST_RANGE;
        end
      end
      default: begin
        // unused opcodes are refused as out of range
        status = iddl_pkg::ST_RANGE;
      end
    endcase
  end

  assign ok = (status == iddl_pkg::ST_OK);

  // control broadcast to the cells, only on an accepted and valid request
  always_comb begin
    ctl     = '0;
    ctl.ins = acc && ok && (req_i.cmd == iddl_pkg::CMD_INSERT);
    ctl.del = acc && ok && (req_i.cmd == iddl_pkg::CMD_DELETE);
    ctl.upd = acc && ok && (req_i.cmd == iddl_pkg::CMD_UPDATE);
    ctl.rd  = acc && ok && (req_i.cmd == iddl_pkg::CMD_READ);
  end

  // next length
  always_comb begin
    cnt_d = cnt_q;
    if (acc && (req_i.cmd == iddl_pkg::CMD_CLEAR)) begin
      cnt_d = '0;
    end else if (ctl.ins) begin
      cnt_d = cnt_q + CW'(1);
    end else if (ctl.del) begin
      cnt_d = cnt_q - CW'(1);
    end
  end
  assign cnt_dw = WW'(cnt_d);

  // the row of cells; ends of the chain see zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = 32'sd0;
    end else begin : g_mid_l
      assign left_w = ent_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = 32'sd0;
    end else begin : g_mid_r
      assign right_w = ent_w[i+1];
    end
    iddl_cell #(
      .IDX (i),
      .PW  (WW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .pos_i   (pos_w),
      .val_i   (req_i.item_value),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (ent_w[i]),
      .rd_o    (rd_w[i])
    );
  end

  // read path, first stage: or of each group of sixteen cells, registered
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_d[g] = '0;
      for (int k = 0; k < GS; k++) begin
        if (g * GS + k < DEPTH) begin
          grp_d[g] = grp_d[g] | rd_w[g*GS+k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  // read path, second stage: or across the group registers
  always_comb begin
    tree_or = '0;
    for (int g = 0; g < NGRP; g++) begin
      tree_or = tree_or | grp_q[g];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      done_q    <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      done_q    <= (acc && !ctl.rd) || rd_pend_q;
      rd_pend_q <= ctl.rd;
    end
  end

  // response register; a pending read only fills in the data
  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      rsp_q.read_data <= tree_or;
    end else if (acc) begin
      rsp_q.status      <= status;
      rsp_q.list_length <= cnt_dw[7:0];
      rsp_q.read_data   <= 32'sd0;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // length never runs past the cell count
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(cnt_q) <= DepthW)
    else $error("list length exceeds depth");

  // a non-read request is answered in the next cycle
  a_fast_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !ctl.rd) |=> done_o)
    else $error("missing one-cycle response");

  // a pending read always completes in the next cycle
  a_rd_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (done_o && !busy))
    else $error("read did not complete");

  // a read leaves the length unchanged
  a_rd_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.rd |=> $stable(cnt_q))
    else $error("read changed the list length");

endmodule
